@@ design/lsre_pkg.sv @@
package lsre_pkg;

	typedef enum logic [2:0] {
		MODE_CONNECT = 3'd0,
		MODE_WRITE   = 3'd1,
		MODE_READ    = 3'd2,
		MODE_STOP    = 3'd3,
		MODE_LUX     = 3'd4
	} mode_t;

	typedef enum logic [2:0] {
		SRC_ZERO = 3'd0,
		SRC_BYTE = 3'd1,
		SRC_MEM  = 3'd2,
		SRC_D0LO = 3'd3,
		SRC_D0HI = 3'd4
	} src_t;

	localparam logic [7:0] CMD_SWRESET  = 8'hE4;
	localparam logic [7:0] TIMING_RESET = 8'hDA;
	localparam logic [7:0] CTRL_VALID   = 8'h10;
	localparam int unsigned CMD_FLAG_BIT = 7;

	localparam logic [6:0] ADDR_CONTROL = 7'h00;
	localparam logic [6:0] ADDR_TIMING  = 7'h01;
	localparam logic [6:0] ADDR_D0_LO   = 7'h14;
	localparam logic [6:0] ADDR_D0_HI   = 7'h15;
	localparam logic [6:0] ADDR_D1_LO   = 7'h16;
	localparam logic [6:0] ADDR_D1_HI   = 7'h17;

	localparam logic [16:0] LUX_RESET   = 17'd800;
	localparam logic [7:0]  D1_LO_VAL   = 8'h01;
	localparam logic [7:0]  D1_HI_VAL   = 8'h00;

	// data0 = (100*lux + 258) / 129, division by reciprocal (exact below 2^31/121)
	localparam logic [23:0] LUX_SCALE = 24'd100;
	localparam logic [23:0] LUX_BIAS  = 24'd258;
	localparam logic [24:0] RECIP_129 = 25'd16647161;
	localparam int unsigned RECIP_SHIFT = 31;
	localparam logic [17:0] D0_MIN = 18'd4;
	localparam logic [17:0] D0_MAX = 18'd65535;

	typedef struct packed {
		logic        ack;
		src_t        src;
		logic [7:0]  byte_val;
		logic        mem_ok;
		logic [23:0] num;
	} rd_info_t;

endpackage

@@ design/lsre_regfile.sv @@
module lsre_regfile #(
	parameter int REG_COUNT = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              adv,
	input  logic [2:0]        mode,
	input  logic [7:0]        data_byte,
	input  logic [16:0]       lux_value,
	output logic              vld_s1,
	output lsre_pkg::rd_info_t info_s1,
	output logic [7:0]        mem_rd_s1
);
	import lsre_pkg::*;

	localparam int IW = $clog2(REG_COUNT);
	localparam logic [7:0] RegCnt = 8'(REG_COUNT);

	logic [7:0]           mem [REG_COUNT];
	logic [REG_COUNT-1:0] mem_vld_q, mem_vld_d;

	logic [7:0]  ctrl_q, ctrl_d, timing_q, timing_d;
	logic [7:0]  d0lo_q, d0lo_d, d0hi_q, d0hi_d, d1lo_q, d1lo_d, d1hi_q, d1hi_d;
	logic        live_lo_q, live_lo_d, live_hi_q, live_hi_d;
	logic [16:0] lux_q, lux_d;
	logic [6:0]  ptr_q, ptr_d, rreg_q, rreg_d;
	logic        pend_q, pend_d;
	logic [1:0]  roff_q, roff_d;

	logic        mem_we;
	logic [6:0]  rd_addr;
	logic        rd_ok;
	rd_info_t    info_d;

	always_comb begin
		ctrl_d    = ctrl_q;
		timing_d  = timing_q;
		d0lo_d    = d0lo_q;
		d0hi_d    = d0hi_q;
		d1lo_d    = d1lo_q;
		d1hi_d    = d1hi_q;
		live_lo_d = live_lo_q;
		live_hi_d = live_hi_q;
		lux_d     = lux_q;
		ptr_d     = ptr_q;
		rreg_d    = rreg_q;
		pend_d    = pend_q;
		roff_d    = roff_q;
		mem_vld_d = mem_vld_q;
		mem_we    = 1'b0;
		rd_addr   = rreg_q;
		rd_ok     = 1'b0;
		info_d.ack      = 1'b1;
		info_d.src      = SRC_ZERO;
		info_d.byte_val = 8'h00;
		info_d.mem_ok   = 1'b0;
		info_d.num      = 24'(lux_q) * LUX_SCALE + LUX_BIAS;

		case (mode_t'(mode))
			MODE_CONNECT: begin
				pend_d = 1'b0;
				roff_d = 2'd0;
			end
			MODE_WRITE: begin
				if (data_byte == CMD_SWRESET) begin
					ctrl_d    = 8'h00;
					timing_d  = TIMING_RESET;
					d0lo_d    = 8'h00;
					d0hi_d    = 8'h00;
					d1lo_d    = 8'h00;
					d1hi_d    = 8'h00;
					live_lo_d = 1'b0;
					live_hi_d = 1'b0;
					mem_vld_d = '0;
					pend_d    = 1'b0;
				end else if (!pend_q) begin
					if (!data_byte[CMD_FLAG_BIT]) begin
						info_d.ack = 1'b0;
					end else begin
						ptr_d  = data_byte[6:0];
						pend_d = 1'b1;
					end
				end else begin
					pend_d = 1'b0;
					if ({1'b0, ptr_q} < RegCnt) begin
						case (ptr_q)
							ADDR_CONTROL: begin
								ctrl_d    = data_byte | CTRL_VALID;
								live_lo_d = 1'b1;
								live_hi_d = 1'b1;
								d1lo_d    = D1_LO_VAL;
								d1hi_d    = D1_HI_VAL;
							end
							ADDR_TIMING: timing_d = data_byte;
							ADDR_D0_LO: begin
								d0lo_d    = data_byte;
								live_lo_d = 1'b0;
							end
							ADDR_D0_HI: begin
								d0hi_d    = data_byte;
								live_hi_d = 1'b0;
							end
							ADDR_D1_LO: d1lo_d = data_byte;
							ADDR_D1_HI: d1hi_d = data_byte;
							default: begin
								mem_we = 1'b1;
								mem_vld_d[ptr_q[IW-1:0]] = 1'b1;
							end
						endcase
					end
				end
			end
			MODE_READ: begin
				if (rreg_q == ADDR_D0_LO) begin
					rd_addr = ADDR_D0_LO + {5'd0, roff_q};
					rd_ok   = 1'b1;
					roff_d  = roff_q + 2'd1;
				end else if ({1'b0, rreg_q} < RegCnt) begin
					rd_ok = 1'b1;
				end
				if (rd_ok) begin
					info_d.src = SRC_BYTE;
					case (rd_addr)
						ADDR_CONTROL: info_d.byte_val = ctrl_q;
						ADDR_TIMING:  info_d.byte_val = timing_q;
						ADDR_D0_LO: begin
							info_d.byte_val = d0lo_q;
							if (live_lo_q) begin
								info_d.src = SRC_D0LO;
							end
						end
						ADDR_D0_HI: begin
							info_d.byte_val = d0hi_q;
							if (live_hi_q) begin
								info_d.src = SRC_D0HI;
							end
						end
						ADDR_D1_LO: info_d.byte_val = d1lo_q;
						ADDR_D1_HI: info_d.byte_val = d1hi_q;
						default: begin
							info_d.src    = SRC_MEM;
							info_d.mem_ok = mem_vld_q[rd_addr[IW-1:0]];
						end
					endcase
				end
			end
			MODE_STOP: begin
				if (pend_q) begin
					rreg_d = ptr_q;
					roff_d = 2'd0;
					pend_d = 1'b0;
				end
			end
			MODE_LUX: begin
				lux_d     = lux_value;
				live_lo_d = 1'b1;
				live_hi_d = 1'b1;
				d1lo_d    = D1_LO_VAL;
				d1hi_d    = D1_HI_VAL;
				ctrl_d    = ctrl_q | CTRL_VALID;
			end
			default: info_d.ack = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctrl_q    <= CTRL_VALID;
			timing_q  <= 8'h00;
			d0lo_q    <= 8'h00;
			d0hi_q    <= 8'h00;
			d1lo_q    <= D1_LO_VAL;
			d1hi_q    <= D1_HI_VAL;
			live_lo_q <= 1'b1;
			live_hi_q <= 1'b1;
			lux_q     <= LUX_RESET;
			ptr_q     <= 7'd0;
			rreg_q    <= 7'd0;
			pend_q    <= 1'b0;
			roff_q    <= 2'd0;
			mem_vld_q <= '0;
			vld_s1    <= 1'b0;
		end else begin
			if (accept) begin
				ctrl_q    <= ctrl_d;
				timing_q  <= timing_d;
				d0lo_q    <= d0lo_d;
				d0hi_q    <= d0hi_d;
				d1lo_q    <= d1lo_d;
				d1hi_q    <= d1hi_d;
				live_lo_q <= live_lo_d;
				live_hi_q <= live_hi_d;
				lux_q     <= lux_d;
				ptr_q     <= ptr_d;
				rreg_q    <= rreg_d;
				pend_q    <= pend_d;
				roff_q    <= roff_d;
				mem_vld_q <= mem_vld_d;
				vld_s1    <= 1'b1;
			end else if (adv) begin
				vld_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			info_s1   <= info_d;
			mem_rd_s1 <= mem[rd_addr[IW-1:0]];
			if (mem_we) begin
				mem[ptr_q[IW-1:0]] <= data_byte;
			end
		end
	end

endmodule

@@ design/lsre_conv.sv @@
module lsre_conv (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              vld_s1,
	input  lsre_pkg::rd_info_t info_s1,
	input  logic [7:0]        mem_rd_s1,
	input  logic              m_tready,
	output logic              adv,
	output logic              m_tvalid,
	output logic [15:0]       m_tdata
);
	import lsre_pkg::*;

	logic [48:0] prod;
	logic [17:0] quot;
	logic [15:0] d0;
	logic [7:0]  rd_val;
	logic        out_vld_q;
	logic [7:0]  read_data_q;
	logic        ack_q;

	assign prod = 49'(info_s1.num) * 49'(RECIP_129);
	assign quot = prod[RECIP_SHIFT +: 18];

	always_comb begin
		if (quot < D0_MIN) begin
			d0 = 16'(D0_MIN);
		end else if (quot > D0_MAX) begin
			d0 = 16'(D0_MAX);
		end else begin
			d0 = quot[15:0];
		end
		case (info_s1.src)
			SRC_BYTE: rd_val = info_s1.byte_val;
			SRC_MEM:  rd_val = info_s1.mem_ok ? mem_rd_s1 : 8'h00;
			SRC_D0LO: rd_val = d0[7:0];
			SRC_D0HI: rd_val = d0[15:8];
			default:  rd_val = 8'h00;
		endcase
	end

	assign adv = !out_vld_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= vld_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && vld_s1) begin
			read_data_q <= rd_val;
			ack_q       <= info_s1.ack;
		end
	end

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {7'd0, ack_q, read_data_q};

endmodule

@@ design/light_sensor_register_emulator.sv @@
// Pipeline: register file stage, then conversion stage, each registered; the result is valid
// on the output once it has passed both stage registers after the input transfer.
// Throughput: one bus event per cycle; a stall on the result side backs up through both stages.
// The lux divide is a single reciprocal multiply in the conversion stage.
// Reset (arst_n low): control 0x10, data bytes for 800 lux, pointer and read state cleared,
// all other registers read as zero.
module light_sensor_register_emulator #(
	parameter int REG_COUNT = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [2:0]  s_tuser,   // mode[2:0]
	input  logic [31:0] s_tdata,   // data_byte[7:0], lux_value[24:8], zero pad
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata    // read_data[7:0], ack[8], zero pad
);
	import lsre_pkg::*;

	logic     accept;
	logic     adv;
	logic     vld_s1;
	rd_info_t info_s1;
	logic [7:0] mem_rd_s1;

	assign s_tready = !vld_s1 || adv;
	assign accept   = s_tvalid && s_tready;

	lsre_regfile #(
		.REG_COUNT(REG_COUNT)
	) u_regfile (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.adv       (adv),
		.mode      (s_tuser),
		.data_byte (s_tdata[7:0]),
		.lux_value (s_tdata[24:8]),
		.vld_s1    (vld_s1),
		.info_s1   (info_s1),
		.mem_rd_s1 (mem_rd_s1)
	);

	lsre_conv u_conv (
		.clk       (clk),
		.arst_n    (arst_n),
		.vld_s1    (vld_s1),
		.info_s1   (info_s1),
		.mem_rd_s1 (mem_rd_s1),
		.m_tready  (m_tready),
		.adv       (adv),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata)
	);

endmodule
